// ----- rtl/core/srwm_pkg.sv -----
// ----------------------------------------------------------------------------
// srwm_pkg
// Shared types, widths and the square-root step for the RGB Sobel magnitude
// core.
// ----------------------------------------------------------------------------
package srwm_pkg;

  // Window geometry and item widths
  localparam int unsigned LANES    = 3;              // red, green, blue
  localparam int unsigned WIN_PIX  = 9;              // 3x3 window
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIX_W    = LANES * CHAN_W; // 24
  localparam int unsigned IN_W     = WIN_PIX * PIX_W;
  localparam int unsigned OUT_W    = LANES * CHAN_W;

  // Arithmetic widths inside a lane
  localparam int unsigned GRAD_W   = CHAN_W + 2;     // |gradient| <= 1020
  localparam int unsigned SQ_W     = 2 * GRAD_W;
  localparam int unsigned SUM_W    = SQ_W + 1;       // gx^2 + gy^2 < 2^21
  localparam int unsigned ROOT_W   = CHAN_W;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned REM_W    = ROOT_W + 2;

  // Largest sum that still rounds to a root of at most 255
  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(255 * 255 + 255);
  localparam logic [CHAN_W-1:0] EDGE_MAX = '1;

  // Pipeline depth of one lane: gradient, square, sum, then the root stages
  localparam int unsigned SQRT_STAGES  = ROOT_W / 2;
  localparam int unsigned LANE_STAGES  = 3 + SQRT_STAGES;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [WIN_PIX-1:0] chan_win_t;
  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [RAD_W-1:0] rad_t;

  // Stage load enables handed to every lane
  typedef struct packed {
    logic [LANE_STAGES-1:0] en;
  } srwm_ctrl_t;

  // What a lane hands to the merge stage
  typedef struct packed {
    root_t root;
    rem_t  rem;
    logic  sat;
  } lane_res_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
  } sqrt_state_t;

  // One restoring step of the digit-by-digit square root
  function automatic sqrt_state_t sqrt_step(input rem_t rem, input root_t root,
                                            input logic [1:0] pair);
    rem_t        shifted;
    rem_t        trial;
    sqrt_state_t st;
    shifted = {rem[REM_W-3:0], pair};
    trial   = {1'b0, root[ROOT_W-2:0], 2'b01};
    if (shifted >= trial) begin
      st.rem  = shifted - trial;
      st.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      st.rem  = shifted;
      st.root = {root[ROOT_W-2:0], 1'b0};
    end
    return st;
  endfunction

endpackage

// ----- rtl/core/srwm_lane.sv -----
// ----------------------------------------------------------------------------
// srwm_lane
// One color channel: Sobel gradients, squares, sum with saturation check and
// a pipelined square root, two root bits per stage.
// ----------------------------------------------------------------------------
module srwm_lane (
  input  logic               clk,
  input  srwm_pkg::srwm_ctrl_t ctrl,
  input  srwm_pkg::chan_win_t  pix,
  output srwm_pkg::lane_res_t  res
);
  import srwm_pkg::*;

  logic [GRAD_W-1:0] xr, xl, yb, yt;
  logic [GRAD_W-1:0] ax_nxt, ay_nxt;
  logic [GRAD_W-1:0] ax_r, ay_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [SUM_W-1:0]  sum;
  rad_t              rad_r;
  logic              sat_r;

  rem_t  rem_r  [SQRT_STAGES];
  root_t root_r [SQRT_STAGES];
  rad_t  srad_r [SQRT_STAGES];
  logic  ssat_r [SQRT_STAGES];

  // Column and row sums with weights 1,2,1
  always_comb begin
    xr = GRAD_W'(pix[2]) + {1'b0, pix[5], 1'b0} + GRAD_W'(pix[8]);
    xl = GRAD_W'(pix[0]) + {1'b0, pix[3], 1'b0} + GRAD_W'(pix[6]);
    yb = GRAD_W'(pix[6]) + {1'b0, pix[7], 1'b0} + GRAD_W'(pix[8]);
    yt = GRAD_W'(pix[0]) + {1'b0, pix[1], 1'b0} + GRAD_W'(pix[2]);
    ax_nxt = (xr >= xl) ? xr - xl : xl - xr;
    ay_nxt = (yb >= yt) ? yb - yt : yt - yb;
    sum = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  end

  // Hold absolute gradients, then their squares, then the radicand
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
    if (ctrl.en[1]) begin
      sqx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sqy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    end
    if (ctrl.en[2]) begin
      rad_r <= sum[RAD_W-1:0];
      sat_r <= (sum > SAT_LIMIT);
    end
  end

  // Square root: each stage resolves two root bits, high bits first
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    rem_t        rem_in;
    root_t       root_in;
    rad_t        rad_in;
    logic        sat_in;
    sqrt_state_t st_a, st_b;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_r;
      assign sat_in  = sat_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = srad_r[k-1];
      assign sat_in  = ssat_r[k-1];
    end

    always_comb begin
      st_a = sqrt_step(rem_in, root_in, rad_in[RAD_W-1-4*k -: 2]);
      st_b = sqrt_step(st_a.rem, st_a.root, rad_in[RAD_W-3-4*k -: 2]);
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[3+k]) begin
        rem_r[k]  <= st_b.rem;
        root_r[k] <= st_b.root;
        srad_r[k] <= rad_in;
        ssat_r[k] <= sat_in;
      end
    end
  end

  assign res.root = root_r[SQRT_STAGES-1];
  assign res.rem  = rem_r[SQRT_STAGES-1];
  assign res.sat  = ssat_r[SQRT_STAGES-1];

endmodule

// ----- rtl/core/srwm_merge.sv -----
// ----------------------------------------------------------------------------
// srwm_merge
// Rounds and saturates the three lane roots and holds the packed result
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module srwm_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          lane_valid,
  input  srwm_pkg::lane_res_t           res [srwm_pkg::LANES],
  output logic                          load,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [srwm_pkg::OUT_W-1:0]    out_tdata  // red, green, blue
);
  import srwm_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] data_r, data_nxt;

  // Round to nearest: bump the root when the remainder exceeds it
  always_comb begin
    logic [ROOT_W:0] rnd;
    data_nxt = '0;
    for (int c = 0; c < LANES; c++) begin
      rnd = {1'b0, res[c].root} + (ROOT_W+1)'(res[c].rem > REM_W'(res[c].root));
      if (res[c].sat || rnd[ROOT_W]) begin
        data_nxt[c*CHAN_W +: CHAN_W] = EDGE_MAX;
      end else begin
        data_nxt[c*CHAN_W +: CHAN_W] = rnd[ROOT_W-1:0];
      end
    end
  end

  // Take a new item when the register is empty or being drained
  assign load          = !out_valid_r || out_tready;
  assign out_valid_nxt = load ? lane_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- rtl/core/sobel_rgb_window_magnitude_core.sv -----
// ----------------------------------------------------------------------------
// sobel_rgb_window_magnitude_core
// Sobel gradient magnitude of a 3x3 RGB window, one lane per color channel.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_tvalid/in_tready/in_tdata) carries one 3x3 window
//   per item: nine 24-bit pixels, top-left first, row by row; each pixel is
//   red 23:16, green 15:8, blue 7:0.
//   The output channel (out_tvalid/out_tready/out_tdata) carries one item per
//   window: red edge 7:0, green edge 15:8, blue edge 23:16, each the rounded
//   magnitude sqrt(gx^2+gy^2), saturated at 255.
//   An accepted window passes seven stages in each lane (gradient, square,
//   sum, four square-root stages of two bits each) and the output register.
//   Throughput is one window per cycle while out_tready stays high.
//   A stalled receiver holds the output register; stages upstream keep
//   filling until they run out of empty slots, then in_tready drops.
//   Synchronous reset clears every valid flag; no item is in flight after it.
// ----------------------------------------------------------------------------
module sobel_rgb_window_magnitude_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pixel_top_left, pixel_top_mid, pixel_top_right, pixel_mid_left,
  // pixel_center, pixel_mid_right, pixel_bottom_left, pixel_bottom_mid,
  // pixel_bottom_right (24 bits each)
  input  logic [srwm_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // red_edge, green_edge, blue_edge (8 bits each)
  output logic [srwm_pkg::OUT_W-1:0]  out_tdata
);
  import srwm_pkg::*;

  logic [LANE_STAGES-1:0] valid_r, valid_nxt;
  logic [LANE_STAGES:0]   ready;
  logic                   load;
  srwm_ctrl_t             ctrl;
  lane_res_t              res [LANES];

  // Ready ripples back: a stage loads when empty or when its item moves on
  always_comb begin
    ready[LANE_STAGES] = load;
    for (int i = LANE_STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid_r[i] || ready[i+1];
    end
    for (int i = 0; i < LANE_STAGES; i++) begin
      if (i == 0) begin
        valid_nxt[i] = ready[i] ? in_tvalid : valid_r[i];
      end else begin
        valid_nxt[i] = ready[i] ? valid_r[i-1] : valid_r[i];
      end
    end
    ctrl.en = ready[LANE_STAGES-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready = ready[0];

  // One lane per channel, red first
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    chan_win_t pix;
    for (genvar k = 0; k < WIN_PIX; k++) begin : g_pix
      assign pix[k] = in_tdata[k*PIX_W + (LANES-1-c)*CHAN_W +: CHAN_W];
    end
    srwm_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .pix  (pix),
      .res  (res[c])
    );
  end

  srwm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (valid_r[LANE_STAGES-1]),
    .res        (res),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB Sobel window magnitude core. Windows go in
// with random gaps while the receiver stalls at random. Every result item is
// compared per channel against an integer model of the Sobel magnitude
// (exact rounding, saturation at 255). A short table of corner windows comes
// first, then a random mix of noise, smooth patches and two-color edges.
// ----------------------------------------------------------------------------
module tb_top;

  import srwm_pkg::*;

  localparam int unsigned RAND_ITEMS   = 550;
  localparam int unsigned N_DIR        = 19;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RED_LSB      = 2 * CHAN_W;
  localparam int unsigned GREEN_LSB    = CHAN_W;
  localparam int unsigned BLUE_LSB     = 0;

  typedef logic [PIX_W-1:0]      pixel_t;
  typedef pixel_t [WIN_PIX-1:0]  window_t;

  // Red lands in the low byte of the result item
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } edges_t;

  typedef enum int {
    PX_TOP_LEFT, PX_TOP_MID, PX_TOP_RIGHT,
    PX_MID_LEFT, PX_CENTER, PX_MID_RIGHT,
    PX_BOTTOM_LEFT, PX_BOTTOM_MID, PX_BOTTOM_RIGHT
  } pix_pos_t;

  typedef struct {
    pixel_t pix [WIN_PIX];
    bit     known;
    edges_t want;
  } window_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;

  edges_t      edges_due [$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned windows_sent;
  int unsigned cycles;
  bit          steady;

  // Corner windows, listed row by row (top, middle, bottom); expected edges
  // are given as blue, green, red
  window_row_t dir_table [N_DIR] = '{
    // flat black
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    // flat white
    '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    // full-scale falling edge across columns, saturates
    '{'{24'hFFFFFF, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'h000000, 24'h000000}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    // full-scale rising edge across columns
    '{'{24'h000000, 24'h000000, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'hFFFFFF}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    // full-scale falling edge across rows
    '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    // full-scale rising edge across rows
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    // small column step, distinct per channel to catch lane swaps
    '{'{24'h000000, 24'h000000, 24'h010203,
        24'h000000, 24'h000000, 24'h010203,
        24'h000000, 24'h000000, 24'h010203}, 1'b1, '{8'd12, 8'd8, 8'd4}},
    // small row step, reversed channel order
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000,
        24'h030201, 24'h030201, 24'h030201}, 1'b1, '{8'd4, 8'd8, 8'd12}},
    // center carries no weight
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'hFFFFFF, 24'h000000,
        24'h000000, 24'h000000, 24'h000000}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    // lone corner, diagonal gradient saturates
    '{'{24'hFFFFFF, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    // one below, one above and one well under the saturation point
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h7F8040,
        24'h000000, 24'h000000, 24'h000000}, 1'b1, '{8'd128, 8'd255, 8'd254}},
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h01FF00, 24'h000000}, 1'b1, '{8'd0, 8'd255, 8'd2}},
    // rounding of small non-square sums
    '{'{24'h000000, 24'h000000, 24'h010101,
        24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h010101, 24'h000000}, 1'b0, '0},
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h010203,
        24'h000000, 24'h030201, 24'h000000}, 1'b0, '0},
    // checkerboard of alternating bit patterns
    '{'{24'hAAAAAA, 24'h555555, 24'hAAAAAA,
        24'h555555, 24'hAAAAAA, 24'h555555,
        24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 1'b0, '0},
    // unrelated pixels
    '{'{24'h123456, 24'h789ABC, 24'hDEF012,
        24'h345678, 24'h9ABCDE, 24'hF01234,
        24'h56789A, 24'hBCDEF0, 24'h0F1E2D}, 1'b0, '0},
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000001,
        24'h000000, 24'h010101, 24'h010101}, 1'b0, '0},
    // just at the saturation point with a tiny vertical part
    '{'{24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h7F7F7F,
        24'h000000, 24'h000000, 24'h010101}, 1'b0, '0},
    // diagonal ramp
    '{'{24'h000000, 24'h204060, 24'h4080C0,
        24'h204060, 24'h4080C0, 24'h60A0E0,
        24'h4080C0, 24'h60A0E0, 24'h80C0FF}, 1'b0, '0}
  };

  sobel_rgb_window_magnitude_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Magnitude of one channel: exact integer root, round to nearest, clamp
  function automatic chan_t edge_magnitude(input window_t w, input int unsigned lsb);
    int c [WIN_PIX];
    int gx;
    int gy;
    int sum_sq;
    int root;
    int trial;
    for (int k = 0; k < WIN_PIX; k++) c[k] = int'(w[k][lsb +: CHAN_W]);
    gx = (c[PX_TOP_RIGHT] + 2 * c[PX_MID_RIGHT] + c[PX_BOTTOM_RIGHT])
       - (c[PX_TOP_LEFT] + 2 * c[PX_MID_LEFT] + c[PX_BOTTOM_LEFT]);
    gy = (c[PX_BOTTOM_LEFT] + 2 * c[PX_BOTTOM_MID] + c[PX_BOTTOM_RIGHT])
       - (c[PX_TOP_LEFT] + 2 * c[PX_TOP_MID] + c[PX_TOP_RIGHT]);
    sum_sq = gx * gx + gy * gy;
    // Sum stays below 2^21, so the root fits in 11 bits
    root = 0;
    for (int b = 10; b >= 0; b--) begin
      trial = root + (1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    if (sum_sq - root * root > root) root++;
    return (root > 255) ? chan_t'(255) : chan_t'(root);
  endfunction

  function automatic edges_t predict_edges(input window_t w);
    edges_t e;
    e.red   = edge_magnitude(w, RED_LSB);
    e.green = edge_magnitude(w, GREEN_LSB);
    e.blue  = edge_magnitude(w, BLUE_LSB);
    return e;
  endfunction

  // Gap or stall length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Nudge a channel value by up to +-spread, clamped to the channel range
  function automatic chan_t jitter(input chan_t base, input int unsigned spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  // Mix of pure noise, smooth patches and two-color edges; the latter two keep
  // most magnitudes below saturation so rounding is exercised
  function automatic window_t random_window();
    window_t     w;
    pixel_t      base;
    pixel_t      other;
    int unsigned mode;
    int unsigned spread;
    mode   = $urandom_range(0, 99);
    base   = pixel_t'($urandom);
    spread = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 40) : $urandom_range(41, 255);
    for (int c = 0; c < LANES; c++)
      other[c*CHAN_W +: CHAN_W] = jitter(base[c*CHAN_W +: CHAN_W], spread);
    for (int k = 0; k < WIN_PIX; k++) begin
      if (mode < 25) begin
        w[k] = pixel_t'($urandom);
      end else if (mode < 70) begin
        for (int c = 0; c < LANES; c++)
          w[k][c*CHAN_W +: CHAN_W] = jitter(base[c*CHAN_W +: CHAN_W], spread);
      end else begin
        w[k] = ($urandom_range(0, 1) != 0) ? base : other;
      end
    end
    return w;
  endfunction

  // Offer one window, hold it until accepted, then record what must come back
  task automatic push_window(input window_t w, input bit known, input edges_t want);
    int unsigned gap;
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    edges_due.push_back(known ? want : predict_edges(w));
    windows_sent++;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic compare_chan(input string name, input chan_t want, input chan_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, edges_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stall stretches, always ready during steady phases
  initial begin
    int unsigned hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_tready <= 1'b1;
        hold = 0;
      end else if (hold != 0) begin
        hold--;
      end else begin
        out_tready <= ($urandom_range(0, 2) != 0);
        hold = idle_len();
      end
    end
  end

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    edges_t want;
    edges_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (edges_due.size() == 0) begin
        $error("result item %h arrived with nothing expected", got);
        mismatches++;
      end else begin
        want = edges_due.pop_front();
        compare_chan("red_edge", want.red, got.red);
        compare_chan("green_edge", want.green, got.green);
        compare_chan("blue_edge", want.blue, got.blue);
        results_checked++;
      end
    end
  end

  // Stimulus
  initial begin
    window_t win;
    windows_sent    = 0;
    steady          = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    for (int i = 0; i < N_DIR; i++) begin
      for (int k = 0; k < WIN_PIX; k++) win[k] = dir_table[i].pix[k];
      push_window(win, dir_table[i].known, dir_table[i].want);
    end

    // Random windows, with one back-to-back stretch at full rate
    for (int i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 200 && i < 280);
      push_window(random_window(), 1'b0, '0);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then let the pipeline settle
    while (edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d windows (%0d corner cases, %0d random) with random gaps and stalls",
             windows_sent, N_DIR, RAND_ITEMS);
    $display("checked %0d edge results per channel, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
